// ----- rtl/sit_pkg.sv -----
// Shared types and constants for the segment intersection test.
`default_nettype none
package sit_pkg;

	// Orientation products per segment pair: a1a2 vs b1, a1a2 vs b2, b1b2 vs a1, b1b2 vs a2.
	localparam int unsigned NUM_ORIENT = 4;
	localparam int unsigned ORIENT_IDX_BITS = 2;

	localparam logic [ORIENT_IDX_BITS-1:0] ORIENT_A_B1 = 2'd0;
	localparam logic [ORIENT_IDX_BITS-1:0] ORIENT_A_B2 = 2'd1;
	localparam logic [ORIENT_IDX_BITS-1:0] ORIENT_B_A1 = 2'd2;
	localparam logic [ORIENT_IDX_BITS-1:0] ORIENT_B_A2 = 2'd3;

	// Sign of one orientation product; both clear means collinear.
	typedef struct packed {
		logic pos;
		logic neg;
	} orient_sign_t;

endpackage
`default_nettype wire

// ----- rtl/segment_intersection_test.sv -----
// Three-stage pipelined segment intersection test using exact orientation products.
//
//  channel | signals                                   | direction | transaction
//  --------+-------------------------------------------+-----------+--------------------------
//  input   | in_valid, in_ready, seg_a_*_x/y, seg_b_*  | in        | one pair of segments
//  output  | out_valid, out_ready, intersects          | out       | one intersect flag
//
// Stage 1 forms coordinate differences and bounding-box checks, stage 2 holds
// the eight products, and stage 3 holds the compared signs folded into the result.
// One transaction enters per clock unless a full, stalled pipe holds in_ready low.
// The stage with the widest logic is stage 2, one (COORD_BITS+1)-bit multiplier per product.
// A stall on out_ready freezes only the stages that are full; empty stages keep filling.
// arst_n clears the stage valid bits; data registers are not reset.
`default_nettype none
module segment_intersection_test import sit_pkg::*; #(
	parameter int unsigned COORD_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [COORD_BITS-1:0] seg_a_start_x,
	input  logic signed [COORD_BITS-1:0] seg_a_start_y,
	input  logic signed [COORD_BITS-1:0] seg_a_end_x,
	input  logic signed [COORD_BITS-1:0] seg_a_end_y,
	input  logic signed [COORD_BITS-1:0] seg_b_start_x,
	input  logic signed [COORD_BITS-1:0] seg_b_start_y,
	input  logic signed [COORD_BITS-1:0] seg_b_end_x,
	input  logic signed [COORD_BITS-1:0] seg_b_end_y,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         intersects
);

	// Differences need one extra bit; their products are exact in twice that.
	localparam int unsigned DIFF_BITS = COORD_BITS + 1;
	localparam int unsigned PROD_BITS = 2 * DIFF_BITS;

	// Pipeline valid bits and per-stage advance enables.
	logic valid_s1, valid_s2, valid_s3;
	logic adv_s1, adv_s2, adv_s3;

	// A stage may load when it is empty or its contents move on this cycle.
	assign adv_s3   = !valid_s3 || out_ready;
	assign adv_s2   = !valid_s2 || adv_s3;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= in_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
			if (adv_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Stage 1: pick p, q, r for each orientation, subtract, and check boxes.
	// orient(p, q, r) = (qx-px)*(ry-py) - (qy-py)*(rx-px)
	// ---------------------------------------------------------------------
	logic signed [COORD_BITS-1:0] px_c [NUM_ORIENT];
	logic signed [COORD_BITS-1:0] py_c [NUM_ORIENT];
	logic signed [COORD_BITS-1:0] qx_c [NUM_ORIENT];
	logic signed [COORD_BITS-1:0] qy_c [NUM_ORIENT];
	logic signed [COORD_BITS-1:0] rx_c [NUM_ORIENT];
	logic signed [COORD_BITS-1:0] ry_c [NUM_ORIENT];

	logic signed [DIFF_BITS-1:0] dqx_c [NUM_ORIENT];
	logic signed [DIFF_BITS-1:0] dry_c [NUM_ORIENT];
	logic signed [DIFF_BITS-1:0] dqy_c [NUM_ORIENT];
	logic signed [DIFF_BITS-1:0] drx_c [NUM_ORIENT];
	logic [NUM_ORIENT-1:0]       box_c;

	always_comb begin
		// Segment A as the base line, B's endpoints as the probes.
		px_c[ORIENT_A_B1] = seg_a_start_x;  py_c[ORIENT_A_B1] = seg_a_start_y;
		qx_c[ORIENT_A_B1] = seg_a_end_x;    qy_c[ORIENT_A_B1] = seg_a_end_y;
		rx_c[ORIENT_A_B1] = seg_b_start_x;  ry_c[ORIENT_A_B1] = seg_b_start_y;
		px_c[ORIENT_A_B2] = seg_a_start_x;  py_c[ORIENT_A_B2] = seg_a_start_y;
		qx_c[ORIENT_A_B2] = seg_a_end_x;    qy_c[ORIENT_A_B2] = seg_a_end_y;
		rx_c[ORIENT_A_B2] = seg_b_end_x;    ry_c[ORIENT_A_B2] = seg_b_end_y;
		// Segment B as the base line, A's endpoints as the probes.
		px_c[ORIENT_B_A1] = seg_b_start_x;  py_c[ORIENT_B_A1] = seg_b_start_y;
		qx_c[ORIENT_B_A1] = seg_b_end_x;    qy_c[ORIENT_B_A1] = seg_b_end_y;
		rx_c[ORIENT_B_A1] = seg_a_start_x;  ry_c[ORIENT_B_A1] = seg_a_start_y;
		px_c[ORIENT_B_A2] = seg_b_start_x;  py_c[ORIENT_B_A2] = seg_b_start_y;
		qx_c[ORIENT_B_A2] = seg_b_end_x;    qy_c[ORIENT_B_A2] = seg_b_end_y;
		rx_c[ORIENT_B_A2] = seg_a_end_x;    ry_c[ORIENT_B_A2] = seg_a_end_y;

		for (int k = 0; k < NUM_ORIENT; k++) begin
			// Sign-extend by one bit so the difference cannot wrap.
			dqx_c[k] = $signed({qx_c[k][COORD_BITS-1], qx_c[k]})
				- $signed({px_c[k][COORD_BITS-1], px_c[k]});
			dry_c[k] = $signed({ry_c[k][COORD_BITS-1], ry_c[k]})
				- $signed({py_c[k][COORD_BITS-1], py_c[k]});
			dqy_c[k] = $signed({qy_c[k][COORD_BITS-1], qy_c[k]})
				- $signed({py_c[k][COORD_BITS-1], py_c[k]});
			drx_c[k] = $signed({rx_c[k][COORD_BITS-1], rx_c[k]})
				- $signed({px_c[k][COORD_BITS-1], px_c[k]});
			// r inside the inclusive box of p and q: r >= min and r <= max per axis.
			box_c[k] = (rx_c[k] >= px_c[k] || rx_c[k] >= qx_c[k])
				&& (rx_c[k] <= px_c[k] || rx_c[k] <= qx_c[k])
				&& (ry_c[k] >= py_c[k] || ry_c[k] >= qy_c[k])
				&& (ry_c[k] <= py_c[k] || ry_c[k] <= qy_c[k]);
		end
	end

	logic signed [DIFF_BITS-1:0] dqx_s1 [NUM_ORIENT];
	logic signed [DIFF_BITS-1:0] dry_s1 [NUM_ORIENT];
	logic signed [DIFF_BITS-1:0] dqy_s1 [NUM_ORIENT];
	logic signed [DIFF_BITS-1:0] drx_s1 [NUM_ORIENT];
	logic [NUM_ORIENT-1:0]       box_s1;

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			dqx_s1 <= dqx_c;
			dry_s1 <= dry_c;
			dqy_s1 <= dqy_c;
			drx_s1 <= drx_c;
			box_s1 <= box_c;
		end
	end

	// ---------------------------------------------------------------------
	// Stage 2: the two products of each orientation, one multiplier apiece.
	// ---------------------------------------------------------------------
	logic signed [PROD_BITS-1:0] lhs_s2 [NUM_ORIENT];
	logic signed [PROD_BITS-1:0] rhs_s2 [NUM_ORIENT];
	logic [NUM_ORIENT-1:0]       box_s2;

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			for (int k = 0; k < NUM_ORIENT; k++) begin
				lhs_s2[k] <= PROD_BITS'(dqx_s1[k]) * PROD_BITS'(dry_s1[k]);
				rhs_s2[k] <= PROD_BITS'(dqy_s1[k]) * PROD_BITS'(drx_s1[k]);
			end
			box_s2 <= box_s1;
		end
	end

	// ---------------------------------------------------------------------
	// Stage 3: compare the products to get each sign, then fold the tests.
	// ---------------------------------------------------------------------
	orient_sign_t          sgn_c [NUM_ORIENT];
	logic [NUM_ORIENT-1:0] touch_c;
	logic                  straddle_c;
	logic                  hit_c;

	always_comb begin
		for (int k = 0; k < NUM_ORIENT; k++) begin
			sgn_c[k].pos = lhs_s2[k] > rhs_s2[k];
			sgn_c[k].neg = lhs_s2[k] < rhs_s2[k];
			// Collinear endpoint that also sits within the other segment's box.
			touch_c[k] = !sgn_c[k].pos && !sgn_c[k].neg && box_s2[k];
		end
		// Both pairs of signs strictly opposite: a proper crossing.
		straddle_c = ((sgn_c[ORIENT_A_B1].pos && sgn_c[ORIENT_A_B2].neg)
				|| (sgn_c[ORIENT_A_B1].neg && sgn_c[ORIENT_A_B2].pos))
			&& ((sgn_c[ORIENT_B_A1].pos && sgn_c[ORIENT_B_A2].neg)
				|| (sgn_c[ORIENT_B_A1].neg && sgn_c[ORIENT_B_A2].pos));
		hit_c = straddle_c || (|touch_c);
	end

	logic hit_s3;

	always_ff @(posedge clk) begin
		if (adv_s3 && valid_s2) begin
			hit_s3 <= hit_c;
		end
	end

	assign out_valid  = valid_s3;
	assign intersects = hit_s3;

endmodule
`default_nettype wire

// ----- rtl/sit_checker.sv -----
// Port-level checker for the segment intersection test, bound to the top level.
`default_nettype none
module sit_checker #(
	parameter int unsigned COORD_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_ready,
	input  logic signed [COORD_BITS-1:0] seg_a_start_x,
	input  logic signed [COORD_BITS-1:0] seg_a_start_y,
	input  logic signed [COORD_BITS-1:0] seg_b_start_x,
	input  logic signed [COORD_BITS-1:0] seg_b_start_y,
	input  logic                         out_valid,
	input  logic                         out_ready,
	input  logic                         intersects
);

	// A stalled result holds its value until taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(intersects))
		else $error("stalled result changed or dropped");

	// An empty output stage means the whole pipe can take a transaction.
	assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked while output stage is empty");

	// A draining output lets every stage advance, so input is never blocked.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input blocked while output is being drained");

	// Segments sharing their start point must report a hit, given out_ready stays high as the pair moves through.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && seg_a_start_x == seg_b_start_x
			&& seg_a_start_y == seg_b_start_y) ##1 out_ready ##1 out_ready
		|=> out_valid && intersects)
		else $error("shared endpoint not reported as intersecting");

endmodule

bind segment_intersection_test sit_checker #(
	.COORD_BITS(COORD_BITS)
) u_sit_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.seg_a_start_x (seg_a_start_x),
	.seg_a_start_y (seg_a_start_y),
	.seg_b_start_x (seg_b_start_x),
	.seg_b_start_y (seg_b_start_y),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.intersects    (intersects)
);
`default_nettype wire

// ----- sim/testbench.sv -----
// Self-checking testbench for the pipelined segment intersection test.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned COORD_BITS = 16;
	localparam int unsigned RANDOM_PAIRS = 700;
	localparam int unsigned HOLD_SPACING = 250;

	// One segment pair as offered on the input channel.
	typedef struct {
		logic signed [COORD_BITS-1:0] ax1;
		logic signed [COORD_BITS-1:0] ay1;
		logic signed [COORD_BITS-1:0] ax2;
		logic signed [COORD_BITS-1:0] ay2;
		logic signed [COORD_BITS-1:0] bx1;
		logic signed [COORD_BITS-1:0] by1;
		logic signed [COORD_BITS-1:0] bx2;
		logic signed [COORD_BITS-1:0] by2;
	} seg_pair_t;

	// Shapes of random segment pairs.
	typedef enum int {
		PAIR_WIDE,
		PAIR_TIGHT,
		PAIR_COLLINEAR,
		PAIR_SHARED_END,
		PAIR_POINT,
		PAIR_EXTREME
	} pair_shape_t;

	// Receiver behaviors outside the long hold-offs.
	typedef enum int {
		READY_ALWAYS,
		READY_COIN,
		READY_SPARSE,
		READY_PATTERN
	} ready_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [COORD_BITS-1:0] seg_a_start_x = '0;
	logic signed [COORD_BITS-1:0] seg_a_start_y = '0;
	logic signed [COORD_BITS-1:0] seg_a_end_x = '0;
	logic signed [COORD_BITS-1:0] seg_a_end_y = '0;
	logic signed [COORD_BITS-1:0] seg_b_start_x = '0;
	logic signed [COORD_BITS-1:0] seg_b_start_y = '0;
	logic signed [COORD_BITS-1:0] seg_b_end_x = '0;
	logic signed [COORD_BITS-1:0] seg_b_end_y = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic intersects;

	seg_pair_t pending_pairs[$];   // stimulus not yet offered
	bit hit_expected[$];           // predicted flags, oldest first
	seg_pair_t offered;            // pair currently on the input ports
	bit offer_taken = 1'b0;
	bit failed = 1'b0;
	int unsigned pairs_total = 0;
	int unsigned pairs_taken = 0;
	int unsigned flags_seen = 0;

	segment_intersection_test #(
		.COORD_BITS(COORD_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.seg_a_start_x(seg_a_start_x),
		.seg_a_start_y(seg_a_start_y),
		.seg_a_end_x(seg_a_end_x),
		.seg_a_end_y(seg_a_end_y),
		.seg_b_start_x(seg_b_start_x),
		.seg_b_start_y(seg_b_start_y),
		.seg_b_end_x(seg_b_end_x),
		.seg_b_end_y(seg_b_end_y),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.intersects(intersects)
	);

	// ------------------------------------------------------------------
	// Prediction: exact integer orientation test
	// ------------------------------------------------------------------

	// Sign of (q-p) x (r-p); 17-bit differences give 34-bit products, so
	// longint holds them exactly and the zero test is exact.
	function automatic int cross_sign(longint px, longint py, longint qx, longint qy,
			longint rx, longint ry);
		longint lhs;
		longint rhs;
		lhs = (qx - px) * (ry - py);
		rhs = (qy - py) * (rx - px);
		if (lhs > rhs)
			return 1;
		if (lhs < rhs)
			return -1;
		return 0;
	endfunction

	// True when r lies in the box spanned by p and q, edges included.
	function automatic bit in_span_box(longint px, longint py, longint qx, longint qy,
			longint rx, longint ry);
		return rx >= ((px < qx) ? px : qx) && rx <= ((px < qx) ? qx : px) &&
			ry >= ((py < qy) ? py : qy) && ry <= ((py < qy) ? qy : py);
	endfunction

	function automatic bit segments_meet(seg_pair_t s);
		int s1;
		int s2;
		int s3;
		int s4;
		s1 = cross_sign(s.ax1, s.ay1, s.ax2, s.ay2, s.bx1, s.by1);
		s2 = cross_sign(s.ax1, s.ay1, s.ax2, s.ay2, s.bx2, s.by2);
		s3 = cross_sign(s.bx1, s.by1, s.bx2, s.by2, s.ax1, s.ay1);
		s4 = cross_sign(s.bx1, s.by1, s.bx2, s.by2, s.ax2, s.ay2);
		// proper crossing: each segment strictly straddles the other's line
		if (s1 * s2 < 0 && s3 * s4 < 0)
			return 1'b1;
		// otherwise some endpoint must lie on the other segment
		return (s1 == 0 && in_span_box(s.ax1, s.ay1, s.ax2, s.ay2, s.bx1, s.by1)) ||
			(s2 == 0 && in_span_box(s.ax1, s.ay1, s.ax2, s.ay2, s.bx2, s.by2)) ||
			(s3 == 0 && in_span_box(s.bx1, s.by1, s.bx2, s.by2, s.ax1, s.ay1)) ||
			(s4 == 0 && in_span_box(s.bx1, s.by1, s.bx2, s.by2, s.ax2, s.ay2));
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	function automatic seg_pair_t mk_pair(int ax1, int ay1, int ax2, int ay2,
			int bx1, int by1, int bx2, int by2);
		seg_pair_t p;
		p.ax1 = COORD_BITS'(ax1);
		p.ay1 = COORD_BITS'(ay1);
		p.ax2 = COORD_BITS'(ax2);
		p.ay2 = COORD_BITS'(ay2);
		p.bx1 = COORD_BITS'(bx1);
		p.by1 = COORD_BITS'(by1);
		p.bx2 = COORD_BITS'(bx2);
		p.by2 = COORD_BITS'(by2);
		return p;
	endfunction

	// Coordinate biased toward the edges of the signed range.
	function automatic int edge_coord();
		case ($urandom_range(0, 7))
			0: return -32768;
			1: return -32767;
			2: return -1;
			3: return 0;
			4: return 1;
			5: return 32766;
			6: return 32767;
			default: return int'($signed(COORD_BITS'($urandom)));
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Clock
	// ------------------------------------------------------------------

	initial begin
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Driver: offers pending pairs in bursts with random gaps
	// ------------------------------------------------------------------

	int unsigned burst_left = 0;
	int unsigned gap_left = 0;
	seg_pair_t next_pair;

	always @(negedge clk) begin
		if (arst_n && (!in_valid || offer_taken)) begin
			offer_taken = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_pairs.size() > 0) begin
				next_pair = pending_pairs.pop_front();
				offered = next_pair;
				seg_a_start_x <= next_pair.ax1;
				seg_a_start_y <= next_pair.ay1;
				seg_a_end_x <= next_pair.ax2;
				seg_a_end_y <= next_pair.ay2;
				seg_b_start_x <= next_pair.bx1;
				seg_b_start_y <= next_pair.by1;
				seg_b_end_x <= next_pair.bx2;
				seg_b_end_y <= next_pair.by2;
				in_valid <= 1'b1;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					// new burst: sometimes long and back to back, sometimes short
					burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
						: $urandom_range(0, 8);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: own stall pattern plus periodic long hold-offs
	// ------------------------------------------------------------------

	ready_mode_t ready_mode = READY_ALWAYS;
	int unsigned mode_left = 0;
	int unsigned hold_left = 0;
	int unsigned next_hold_at = 100;
	logic [7:0] ready_mask = 8'hff;
	logic [2:0] mask_phase = '0;

	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (arst_n && flags_seen >= next_hold_at) begin
			// long hold-off: the pipe fills and in_ready must drop
			hold_left = $urandom_range(40, 80);
			next_hold_at += HOLD_SPACING;
			out_ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				ready_mode = ready_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(16, 64);
				ready_mask = 8'($urandom) | 8'h01;
			end
			mode_left--;
			mask_phase <= mask_phase + 3'd1;
			case (ready_mode)
				READY_ALWAYS: out_ready <= 1'b1;
				READY_COIN: out_ready <= 1'($urandom);
				READY_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
				default: out_ready <= ready_mask[mask_phase];
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Monitor: predict on input transactions, check output transactions
	// ------------------------------------------------------------------

	bit hit_want;

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				hit_expected.push_back(segments_meet(offered));
				pairs_taken++;
				offer_taken = 1'b1;
			end
			if (out_valid && out_ready) begin
				flags_seen++;
				if (hit_expected.size() == 0) begin
					$error("intersects: expected nothing, actual %0b", intersects);
					failed = 1'b1;
				end else begin
					hit_want = hit_expected.pop_front();
					if (intersects !== hit_want) begin
						$error("intersects: expected %0b, actual %0b", hit_want, intersects);
						failed = 1'b1;
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus, reset and end of run
	// ------------------------------------------------------------------

	initial begin
		seg_pair_t p;
		seg_pair_t swap;
		pair_shape_t shape;
		int bx, by, dx, dy, m, k;

		// directed pairs
		pending_pairs.push_back(mk_pair(-10, -10, 10, 10, -10, 10, 10, -10));  // plain X
		pending_pairs.push_back(mk_pair(0, 0, 10, 0, 0, 1, 10, 1));  // parallel, apart
		pending_pairs.push_back(mk_pair(0, 0, 10, 0, 5, 0, 15, 0));  // collinear overlap
		pending_pairs.push_back(mk_pair(0, 0, 4, 4, 5, 5, 9, 9));  // collinear, disjoint
		pending_pairs.push_back(mk_pair(0, 0, 5, 5, 5, 5, 10, 0));  // touch at endpoints
		pending_pairs.push_back(mk_pair(0, 0, 10, 0, 5, 0, 5, 7));  // T junction
		pending_pairs.push_back(mk_pair(0, 0, 10, 0, 5, 1, 5, 7));  // near miss
		pending_pairs.push_back(mk_pair(3, 3, 3, 3, 0, 0, 6, 6));  // point on segment
		pending_pairs.push_back(mk_pair(3, 4, 3, 4, 0, 0, 6, 6));  // point off segment
		pending_pairs.push_back(mk_pair(8, 8, 8, 8, 0, 0, 6, 6));  // point on line, past end
		pending_pairs.push_back(mk_pair(7, -2, 7, -2, 7, -2, 7, -2));  // two equal points
		pending_pairs.push_back(mk_pair(7, -2, 7, -2, 7, -1, 7, -1));  // two distinct points
		pending_pairs.push_back(mk_pair(0, -5, 0, 5, 0, 5, 0, 9));  // vertical, end to end
		pending_pairs.push_back(mk_pair(10, 0, 0, 0, 2, 0, 3, 0));  // collinear, contained
		pending_pairs.push_back(mk_pair(0, 0, 0, 0, 0, 0, 0, 0));  // all zero
		pending_pairs.push_back(mk_pair(-32768, -32768, 32767, 32767,
			-32768, 32767, 32767, -32768));  // full-range X
		pending_pairs.push_back(mk_pair(-32768, -32768, 32767, -32768,
			-32768, 32767, 32767, 32767));  // bottom and top edges
		pending_pairs.push_back(mk_pair(-32768, -32768, 0, 0, 0, 0, 32767, 32767));
		pending_pairs.push_back(mk_pair(-32768, -32768, 32767, 32767,
			32767, 32766, -32768, -32767));  // products near the widest
		pending_pairs.push_back(mk_pair(32767, -32768, -32768, 32767, -1, -1, 0, 0));
		pending_pairs.push_back(mk_pair(-32768, 32767, -32768, 32767,
			-32768, -32768, -32768, 32767));  // corner point on left edge

		// random pairs, mostly shapes that land on the boundary cases
		for (int n = 0; n < RANDOM_PAIRS; n++) begin
			shape = pair_shape_t'($urandom_range(0, 5));
			bx = $urandom_range(0, 32000) - 16000;
			by = $urandom_range(0, 32000) - 16000;
			dx = $urandom_range(0, 2000) - 1000;
			dy = $urandom_range(0, 2000) - 1000;
			case (shape)
				PAIR_WIDE: begin
					p = mk_pair($urandom, $urandom, $urandom, $urandom,
						$urandom, $urandom, $urandom, $urandom);
				end
				PAIR_TIGHT: begin
					p = mk_pair($urandom_range(0, 16) - 8, $urandom_range(0, 16) - 8,
						$urandom_range(0, 16) - 8, $urandom_range(0, 16) - 8,
						$urandom_range(0, 16) - 8, $urandom_range(0, 16) - 8,
						$urandom_range(0, 16) - 8, $urandom_range(0, 16) - 8);
				end
				PAIR_COLLINEAR: begin
					p = mk_pair(bx, by, bx + 2 * dx, by + 2 * dy,
						bx, by, bx, by);
					k = $urandom_range(0, 16) - 8;
					m = $urandom_range(0, 16) - 8;
					p.ax2 = COORD_BITS'(bx + ($urandom_range(0, 16) - 8) * dx);
					p.ay2 = COORD_BITS'(by + ($urandom_range(0, 16) - 8) * dy);
					p.ax2 = COORD_BITS'(bx + k * dx);
					p.ay2 = COORD_BITS'(by + k * dy);
					k = $urandom_range(0, 16) - 8;
					p.bx1 = COORD_BITS'(bx + k * dx);
					p.by1 = COORD_BITS'(by + k * dy);
					p.bx2 = COORD_BITS'(bx + m * dx);
					p.by2 = COORD_BITS'(by + m * dy);
				end
				PAIR_SHARED_END: begin
					p = mk_pair($urandom, $urandom, $urandom, $urandom,
						$urandom, $urandom, $urandom, $urandom);
					if ($urandom_range(0, 1) == 0) begin
						p.bx1 = p.ax1;
						p.by1 = p.ay1;
					end else begin
						p.bx1 = p.ax2;
						p.by1 = p.ay2;
					end
					if ($urandom_range(0, 1) == 0) begin
						swap = p;
						p.bx1 = swap.bx2;
						p.by1 = swap.by2;
						p.bx2 = swap.bx1;
						p.by2 = swap.by1;
					end
				end
				PAIR_POINT: begin
					// point somewhere along the line of A, just inside or outside it
					m = $urandom_range(1, 6);
					k = $urandom_range(0, m + 2) - 1;
					p = mk_pair(bx, by, bx + m * dx, by + m * dy,
						bx + k * dx, by + k * dy, bx + k * dx, by + k * dy);
					if ($urandom_range(0, 3) == 0) begin
						p.bx1 = p.bx1 + 1'b1;
						p.bx2 = p.bx1;
					end
					if ($urandom_range(0, 1) == 0) begin
						swap = p;
						p.ax1 = swap.bx1;
						p.ay1 = swap.by1;
						p.ax2 = swap.bx2;
						p.ay2 = swap.by2;
						p.bx1 = swap.ax1;
						p.by1 = swap.ay1;
						p.bx2 = swap.ax2;
						p.by2 = swap.ay2;
					end
				end
				default: begin
					p = mk_pair(edge_coord(), edge_coord(), edge_coord(), edge_coord(),
						edge_coord(), edge_coord(), edge_coord(), edge_coord());
				end
			endcase
			pending_pairs.push_back(p);
		end
		pairs_total = pending_pairs.size();

		// hold reset, then release it away from the sampling edge
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// wait for every pair to go in and every flag to come out
		while (pairs_taken < pairs_total || hit_expected.size() > 0)
			@(posedge clk);
		// drain window: a stray extra flag would show up here
		repeat (8) @(posedge clk);

		if (!failed) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// Watchdog far beyond the slowest legal run.
	initial begin
		#2_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/sit_pkg.sv
rtl/segment_intersection_test.sv
rtl/sit_checker.sv
sim/testbench.sv
